@@ hdl/utfd_pkg.sv @@
// Shared types and constants of the text decoder: request structs, the
// encoding codes, register indexes and the lead byte classes.
// No dependencies.
package utfd_pkg;

  // Encoding register codes.
  localparam logic [1:0] ENC_ASCII = 2'd0;
  localparam logic [1:0] ENC_UTF8  = 2'd1;
  localparam logic [1:0] ENC_UTF16 = 2'd2;
  localparam logic [1:0] ENC_UTF32 = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ENCODING   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN = 1'd1;

  // UTF-16 surrogate decoding constants.
  localparam logic [15:0] SURR_MASK   = 16'hfc00;
  localparam logic [15:0] SURR_HIGH   = 16'hd800;
  localparam logic [15:0] SURR_LOW    = 16'hdc00;
  localparam logic [20:0] SURR_OFFSET = 21'h10000;

  // UTF-8 continuation byte check.
  localparam logic [7:0] CONT_MASK = 8'hc0;
  localparam logic [7:0] CONT_TAG  = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [31:0] code_point;
    logic        malformed;
  } out_item_t;

  // Class of a byte read as a UTF-8 lead byte.
  typedef enum logic [2:0] {
    LEAD_SINGLE,
    LEAD_BAD,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR
  } lead_e;

  // One classified byte as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
    lead_e      lead;
    logic       cont_ok;
    logic [4:0] lead_payload;
  } cmd_t;

endpackage

@@ hdl/utf_text_decoder.sv @@
// Top level of the text decoder: configuration registers, front end,
// request queue and back end. Depends on utfd_pkg, utfd_front,
// utfd_fifo and utfd_back.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid_i/in_stall_o  in_item_i  (data_byte, end_of_stream)
//   out      output     out_valid_o/out_stall_i out_item_o (code_point, malformed)
//   cfg      input      cfg_we_i               cfg_index_i, cfg_data_i
//
// One byte is taken per clock cycle while the request queue is not full.
// A taken byte is written into the request queue and, once the result
// register is free or drains, is decoded into the result register, from
// which its result is offered. The queue depth sets how many bytes are
// taken while the output is stalled. Reset puts the encoding at UTF-8,
// little-endian, with all sequence state clear.
module utf_text_decoder import utfd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [1:0] encoding_q;
  logic       big_endian_q;
  logic       enc_write;

  logic q_full, q_push, q_empty, q_pop;
  cmd_t push_cmd, pop_cmd;

  // Writing the encoding register drops any partial sequence.
  assign enc_write = cfg_we_i && (cfg_index_i == REG_ENCODING);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      encoding_q   <= ENC_UTF8;
      big_endian_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ENCODING:   encoding_q   <= cfg_data_i[1:0];
        REG_BIG_ENDIAN: big_endian_q <= cfg_data_i[0];
        default:        big_endian_q <= big_endian_q;
      endcase
    end
  end

  // The front classifies every byte as a possible UTF-8 lead or
  // continuation; the back decides which reading applies.
  utfd_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  utfd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (pop_cmd)
  );

  // The back pops a request whenever its result register can take a value.
  utfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .encoding_i   (encoding_q),
    .big_endian_i (big_endian_q),
    .clear_i      (enc_write),
    .q_empty_i    (q_empty),
    .q_cmd_i      (pop_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

@@ hdl/utfd_front.sv @@
// Front end of the text decoder: takes input bytes and classifies them
// for UTF-8 use. Depends on utfd_pkg.
module utfd_front import utfd_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cmd_t     q_cmd_o
);

  logic [7:0] b;

  assign b          = in_item_i.data_byte;
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_cmd_o.data_byte     = b;
    q_cmd_o.end_of_stream = in_item_i.end_of_stream;
    q_cmd_o.cont_ok       = (b & CONT_MASK) == CONT_TAG;
    q_cmd_o.lead          = LEAD_BAD;
    q_cmd_o.lead_payload  = '0;
    // The payload keeps the bits below the first zero of the lead byte.
    unique casez (b)
      8'b0???????: begin
        q_cmd_o.lead = LEAD_SINGLE;
      end
      8'b110?????: begin
        q_cmd_o.lead         = LEAD_TWO;
        q_cmd_o.lead_payload = b[4:0];
      end
      8'b1110????: begin
        q_cmd_o.lead         = LEAD_THREE;
        q_cmd_o.lead_payload = {1'b0, b[3:0]};
      end
      8'b11110???: begin
        q_cmd_o.lead         = LEAD_FOUR;
        q_cmd_o.lead_payload = {2'b00, b[2:0]};
      end
      default: begin
        q_cmd_o.lead = LEAD_BAD;
      end
    endcase
  end

endmodule

@@ hdl/utfd_fifo.sv @@
// Short request queue between the front and back of the text decoder.
// Depends on utfd_pkg.
module utfd_fifo import utfd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  cmd_t             entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o    = count_q == CNT_W'(DEPTH);
  assign empty_o   = count_q == '0;
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ hdl/utfd_back.sv @@
// Back end of the text decoder: runs the sequence state for each
// classified byte and holds the result register. Depends on utfd_pkg.
module utfd_back import utfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] encoding_i,
  input  logic       big_endian_i,
  input  logic       clear_i,
  input  logic       q_empty_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o
);

  logic [23:0] asm_q, asm_d;
  logic [1:0]  left_q, left_d;
  logic        bad_q, bad_d;
  logic [9:0]  hsb_q, hsb_d;
  logic        sw_q, sw_d;
  logic        out_valid_q;
  out_item_t   out_q;

  logic        emit;
  out_item_t   res;
  logic [7:0]  b;
  logic        eos;
  logic [23:0] asm8;
  logic [1:0]  left_dec;
  logic [15:0] raw16, unit16;
  logic [31:0] raw32, unit32;
  logic [20:0] pair_cp;
  logic        take;

  assign b        = q_cmd_i.data_byte;
  assign eos      = q_cmd_i.end_of_stream;
  assign asm8     = {asm_q[17:0], b[5:0]};
  assign left_dec = left_q - 1'b1;
  assign raw16    = {asm_q[7:0], b};
  assign unit16   = big_endian_i ? raw16 : {raw16[7:0], raw16[15:8]};
  assign raw32    = {asm_q, b};
  assign unit32   = big_endian_i ? raw32
                                 : {raw32[7:0], raw32[15:8], raw32[23:16], raw32[31:24]};
  assign pair_cp  = SURR_OFFSET + {1'b0, hsb_q, unit16[9:0]};

  // A request moves on when the result register is free or drains now.
  assign q_pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign take    = q_pop_o;

  always_comb begin
    asm_d  = asm_q;
    left_d = left_q;
    bad_d  = bad_q;
    hsb_d  = hsb_q;
    sw_d   = sw_q;
    emit   = 1'b0;
    res    = '0;
    unique case (encoding_i)
      ENC_ASCII: begin
        emit           = 1'b1;
        res.code_point = {24'd0, b};
      end
      ENC_UTF8: begin
        if (left_q == '0) begin
          case (q_cmd_i.lead) inside
            LEAD_SINGLE: begin
              emit           = 1'b1;
              res.code_point = {24'd0, b};
            end
            LEAD_TWO, LEAD_THREE, LEAD_FOUR: begin
              asm_d  = {19'd0, q_cmd_i.lead_payload};
              left_d = (q_cmd_i.lead == LEAD_TWO)   ? 2'd1 :
                       (q_cmd_i.lead == LEAD_THREE) ? 2'd2 : 2'd3;
              bad_d  = 1'b0;
            end
            default: begin
              emit          = 1'b1;
              res.malformed = 1'b1;
            end
          endcase
        end else begin
          bad_d  = bad_q || !q_cmd_i.cont_ok;
          asm_d  = asm8;
          left_d = left_dec;
          if (left_dec == '0) begin
            emit           = 1'b1;
            res.malformed  = bad_d;
            res.code_point = bad_d ? '0 : {8'd0, asm8};
            asm_d          = '0;
            bad_d          = 1'b0;
          end
        end
      end
      ENC_UTF16: begin
        if (left_q == '0) begin
          asm_d  = {16'd0, b};
          left_d = 2'd1;
        end else begin
          asm_d  = '0;
          left_d = '0;
          if (sw_q) begin
            sw_d  = 1'b0;
            hsb_d = '0;
            emit  = 1'b1;
            if ((unit16 & SURR_MASK) != SURR_LOW) begin
              res.malformed = 1'b1;
            end else begin
              res.code_point = {11'd0, pair_cp};
            end
          end else if ((unit16 & SURR_MASK) == SURR_HIGH) begin
            hsb_d = unit16[9:0];
            sw_d  = 1'b1;
          end else begin
            emit           = 1'b1;
            res.code_point = {16'd0, unit16};
          end
        end
      end
      ENC_UTF32: begin
        if (left_q == '0) begin
          asm_d  = {16'd0, b};
          left_d = 2'd3;
        end else begin
          asm_d  = raw32[23:0];
          left_d = left_dec;
          if (left_dec == '0) begin
            asm_d          = '0;
            emit           = 1'b1;
            res.code_point = unit32;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    // A stream that ends mid-sequence reports a truncated sequence.
    if (eos && !emit && (left_d != '0 || sw_d)) begin
      asm_d         = '0;
      left_d        = '0;
      bad_d         = 1'b0;
      hsb_d         = '0;
      sw_d          = 1'b0;
      emit          = 1'b1;
      res           = '0;
      res.malformed = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asm_q       <= '0;
      left_q      <= '0;
      bad_q       <= 1'b0;
      hsb_q       <= '0;
      sw_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clear_i) begin
        asm_q  <= '0;
        left_q <= '0;
        bad_q  <= 1'b0;
        hsb_q  <= '0;
        sw_q   <= 1'b0;
      end else if (take) begin
        asm_q  <= asm_d;
        left_q <= left_d;
        bad_q  <= bad_d;
        hsb_q  <= hsb_d;
        sw_q   <= sw_d;
      end
      if (take) begin
        out_valid_q <= emit;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_surr_only_utf16: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sw_q |-> encoding_i == ENC_UTF16)
    else $error("surrogate pending outside utf16 mode");

  a_utf16_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (encoding_i == ENC_UTF16) |-> left_q <= 2'd1)
    else $error("utf16 byte count out of range");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.malformed) |-> out_q.code_point == '0)
    else $error("malformed result with nonzero code point");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");

endmodule

@@ test/tb_utf_text_decoder.sv @@
// Self-checking testbench of the text decoder: directed and random byte
// streams in all four encodings, with a built-in decoder as reference.
// Depends on utfd_pkg and utf_text_decoder.
module tb_utf_text_decoder;
  import utfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // A run is stuck when no request, no character and no register write has
  // moved for this many cycles. The longest honest quiet stretch is the
  // receiver hold-off below, well under this limit.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned PHASE_BYTES    = 225;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  utf_text_decoder i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Characters the decoder owes us, oldest first.
  out_item_t   pending_chars[$];
  int unsigned mismatches;
  int unsigned bytes_sent;

  // Idling knobs, in percent of cycles.
  int unsigned send_idle_pct;
  int unsigned stall_pct;

  // A long receiver hold-off is requested by bumping hold_req_id; the stall
  // process notices the change and counts the cycles itself.
  int unsigned hold_req_id;

  // Shadow of the configuration registers and of the sequence state.
  logic [1:0]  enc_reg;
  logic        be_reg;
  logic [31:0] asm_word;
  logic [2:0]  left;
  logic        seq_bad;
  logic [9:0]  hi_bits;
  logic        surr_wait;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Reference decoder
  // ---------------------------------------------------------------------

  function automatic void clear_sequence_state();
    asm_word  = '0;
    left      = '0;
    seq_bad   = 1'b0;
    hi_bits   = '0;
    surr_wait = 1'b0;
  endfunction

  // An unfinished sequence hit the end of the stream: flag it and start over.
  function automatic bit truncate_seq(output out_item_t ch);
    clear_sequence_state();
    ch = '{code_point: 32'd0, malformed: 1'b1};
    return 1'b1;
  endfunction

  // Advances the shadow state by one byte. Returns 1 when the byte completes
  // a character (good or malformed), which is then handed back in ch.
  function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                     output out_item_t ch);
    int unsigned ones;
    logic [15:0] unit;
    logic [31:0] word;
    logic [9:0]  hi;
    ch = '{code_point: 32'd0, malformed: 1'b0};
    case (enc_reg)
      ENC_ASCII: begin
        // Plain bytes: the end marker has no meaning here.
        ch.code_point = {24'd0, b};
        return 1'b1;
      end
      ENC_UTF8: begin
        if (left == 0) begin
          if (!b[7]) begin
            ch.code_point = {24'd0, b};
            return 1'b1;
          end
          ones = 0;
          while (ones < 8 && b[7 - ones]) ones++;
          // A lone continuation byte or a lead of five or more ones is
          // rejected on the spot and consumes nothing else.
          if (ones < 2 || ones > 4) begin
            ch.malformed = 1'b1;
            return 1'b1;
          end
          asm_word = {24'd0, b & (8'hff >> (ones + 1))};
          left     = 3'(ones - 1);
          seq_bad  = 1'b0;
          if (eos) return truncate_seq(ch);
          return 1'b0;
        end
        // A bad continuation byte poisons the sequence, but the declared
        // length is still consumed before the error comes out.
        if ((b & CONT_MASK) != CONT_TAG) seq_bad = 1'b1;
        asm_word = {asm_word[25:0], b[5:0]};
        left--;
        if (left == 0) begin
          ch.malformed  = seq_bad;
          ch.code_point = seq_bad ? 32'd0 : asm_word;
          asm_word = '0;
          seq_bad  = 1'b0;
          return 1'b1;
        end
        if (eos) return truncate_seq(ch);
        return 1'b0;
      end
      ENC_UTF16: begin
        if (left == 0) begin
          asm_word = {24'd0, b};
          left     = 3'd1;
          if (eos) return truncate_seq(ch);
          return 1'b0;
        end
        unit     = be_reg ? {asm_word[7:0], b} : {b, asm_word[7:0]};
        asm_word = '0;
        left     = '0;
        if (surr_wait) begin
          // Second half of a pair: anything but a low surrogate is an error.
          hi        = hi_bits;
          surr_wait = 1'b0;
          hi_bits   = '0;
          if ((unit & SURR_MASK) != SURR_LOW) begin
            ch.malformed = 1'b1;
            return 1'b1;
          end
          ch.code_point = {11'd0, SURR_OFFSET} + {12'd0, hi, unit[9:0]};
          return 1'b1;
        end
        if ((unit & SURR_MASK) == SURR_HIGH) begin
          hi_bits   = unit[9:0];
          surr_wait = 1'b1;
          if (eos) return truncate_seq(ch);
          return 1'b0;
        end
        // A lone low surrogate passes through untouched.
        ch.code_point = {16'd0, unit};
        return 1'b1;
      end
      default: begin
        if (left == 0) begin
          asm_word = {24'd0, b};
          left     = 3'd3;
          if (eos) return truncate_seq(ch);
          return 1'b0;
        end
        asm_word = {asm_word[23:0], b};
        left--;
        if (left != 0) begin
          if (eos) return truncate_seq(ch);
          return 1'b0;
        end
        word     = asm_word;
        asm_word = '0;
        // No range check: the full unit comes out as it is.
        ch.code_point = be_reg ? word : {word[7:0], word[15:8], word[23:16], word[31:24]};
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Receiver side: stall generation and result checking
  // ---------------------------------------------------------------------

  initial begin : stall_gen
    int unsigned seen_id;
    int unsigned hold_left;
    seen_id   = 0;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req_id != seen_id) begin
        seen_id   = hold_req_id;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Every character taken from the decoder is matched against the oldest
  // expected one, field by field.
  always @(posedge clk) begin : check_chars
    if (out_valid === 1'b1 && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: code_point %h malformed %b",
               out_item.code_point, out_item.malformed);
        mismatches++;
      end else begin
        if (out_item.code_point !== pending_chars[0].code_point) begin
          $error("code_point: expected %h, got %h",
                 pending_chars[0].code_point, out_item.code_point);
          mismatches++;
        end
        if (out_item.malformed !== pending_chars[0].malformed) begin
          $error("malformed: expected %b, got %b",
                 pending_chars[0].malformed, out_item.malformed);
          mismatches++;
        end
        void'(pending_chars.pop_front());
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) || cfg_we) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_utf_text_decoder: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  function automatic logic rand_eos();
    return $urandom_range(99) < 2;
  endfunction

  // Offers one byte, after an optional idle gap, and returns at the edge
  // that accepts it. Valid stays high afterwards so back-to-back requests
  // need no extra assignment; whoever pauses the stream lowers it.
  task automatic push_byte(input logic [7:0] b, input logic eos);
    int unsigned gap;
    out_item_t   ch;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: b, end_of_stream: eos};
    do @(posedge clk); while (in_stall);
    if (decode_byte(b, eos, ch)) pending_chars.push_back(ch);
    bytes_sent++;
  endtask

  task automatic push_unit16(input logic [15:0] u);
    if (be_reg) begin
      push_byte(u[15:8], rand_eos());
      push_byte(u[7:0], rand_eos());
    end else begin
      push_byte(u[7:0], rand_eos());
      push_byte(u[15:8], rand_eos());
    end
  endtask

  task automatic push_word32(input logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      if (be_reg) push_byte(w[31 - 8*i -: 8], rand_eos());
      else push_byte(w[8*i +: 8], rand_eos());
    end
  endtask

  // Stops sending and waits until the decoder has nothing left in flight.
  // A byte that completes no character leaves no expectation behind, so a
  // few more cycles cover its two-stage trip through the block.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ENCODING) begin
      // Any encoding write, even of the same value, drops a partial sequence.
      enc_reg = value;
      clear_sequence_state();
    end else begin
      be_reg = value[0];
    end
  endtask

  task automatic set_mode(input logic [1:0] enc, input logic be);
    write_reg(REG_BIG_ENDIAN, {1'b0, be});
    write_reg(REG_ENCODING, enc);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 60; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 60; end
      default: begin send_idle_pct = 17; stall_pct = 17; end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Random sequence generators, mostly well-formed with random content
  // ---------------------------------------------------------------------

  task automatic send_utf8_token();
    logic [7:0]  seq [4];
    logic [20:0] cp;
    int unsigned n;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      // Stray byte: may be a lone continuation, a bad lead or a fresh lead.
      push_byte(8'($urandom_range(255)), rand_eos());
      return;
    end
    n = $urandom_range(4, 1);
    case (n)
      1: begin
        cp = 21'($urandom_range(21'h7f));
        seq[0] = {1'b0, cp[6:0]};
      end
      2: begin
        cp = 21'($urandom_range(21'h7ff, 21'h80));
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        cp = 21'($urandom_range(21'hffff, 21'h800));
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        cp = 21'($urandom_range(21'h1fffff, 21'h10000));
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    // Now and then one continuation byte is replaced by an arbitrary byte.
    if (n > 1 && r < 18) seq[$urandom_range(n - 1, 1)] = 8'($urandom_range(255));
    for (int i = 0; i < n; i++) push_byte(seq[i], rand_eos());
  endtask

  task automatic send_utf16_token();
    logic [9:0]  hi;
    logic [9:0]  lo;
    int unsigned r;
    r  = $urandom_range(99);
    hi = 10'($urandom_range(1023));
    lo = 10'($urandom_range(1023));
    if (r < 5) begin
      // A single odd byte shifts the unit alignment.
      push_byte(8'($urandom_range(255)), rand_eos());
    end else if (r < 55) begin
      push_unit16(16'($urandom_range(16'hffff)));
    end else if (r < 85) begin
      push_unit16({6'b110110, hi});
      push_unit16({6'b110111, lo});
    end else if (r < 92) begin
      push_unit16({6'b110111, lo});
    end else begin
      // High surrogate followed by whatever comes: mostly a mismatch.
      push_unit16({6'b110110, hi});
      push_unit16(16'($urandom_range(16'hffff)));
    end
  endtask

  task automatic send_utf32_token();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) push_byte(8'($urandom_range(255)), rand_eos());
    else if (r < 50) push_word32($urandom);
    else push_word32($urandom_range(32'h10ffff));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  task automatic test_ascii();
    set_idling(0);
    set_mode(ENC_ASCII, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b1);
  endtask

  task automatic test_utf8();
    set_idling(3);
    set_mode(ENC_UTF8, 1'b0);
    push_byte(8'h00, 1'b0);
    // Two-byte and the largest four-byte form.
    push_byte(8'hc3, 1'b0);
    push_byte(8'ha9, 1'b0);
    push_byte(8'hf4, 1'b0);
    push_byte(8'h8f, 1'b0);
    push_byte(8'hbf, 1'b0);
    push_byte(8'hbf, 1'b0);
    // Lead bytes with one and with eight leading ones.
    push_byte(8'h80, 1'b0);
    push_byte(8'hff, 1'b0);
    // Broken middle byte: one error, after the third byte.
    push_byte(8'he2, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'hac, 1'b0);
    // Stream ends right on a lead byte.
    push_byte(8'hf0, 1'b1);
  endtask

  task automatic test_utf16();
    set_idling(0);
    set_mode(ENC_UTF16, 1'b0);
    // Surrogate pair D83D DE00, little-endian.
    push_byte(8'h3d, 1'b0);
    push_byte(8'hd8, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hde, 1'b0);
    // High surrogate followed by a plain character.
    push_byte(8'h00, 1'b0);
    push_byte(8'hd8, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h00, 1'b0);
    // Lone low surrogate, completed together with the end marker.
    push_byte(8'hff, 1'b0);
    push_byte(8'hdf, 1'b1);
    // Stream ends in the middle of a unit.
    push_byte(8'h12, 1'b1);
  endtask

  task automatic test_utf32();
    set_idling(2);
    set_mode(ENC_UTF32, 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b1);
    push_byte(8'hab, 1'b1);
  endtask

  // The receiver holds off for a long stretch while bytes keep coming, so
  // the request queue fills and the decoder must stall its input. Then the
  // sender pauses until every character has come out.
  task automatic test_backpressure();
    set_idling(0);
    set_mode(ENC_ASCII, 1'b0);
    hold_req_id++;
    for (int i = 0; i < 24; i++) push_byte(8'($urandom_range(255)), rand_eos());
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Random streams under a series of settings, both byte orders and all
  // encodings, the phases taking turns through the four idling patterns.
  task automatic test_random_mix();
    logic [1:0]  enc_list [8];
    logic        be_list [8];
    int unsigned target;
    enc_list = '{ENC_UTF8, ENC_UTF16, ENC_UTF16, ENC_UTF32,
                 ENC_UTF32, ENC_ASCII, ENC_UTF8, ENC_UTF16};
    be_list  = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    for (int p = 0; p < 8; p++) begin
      set_idling(p % 4);
      set_mode(enc_list[p], be_list[p]);
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        case (enc_reg)
          ENC_ASCII: push_byte(8'($urandom_range(255)), rand_eos());
          ENC_UTF8:  send_utf8_token();
          ENC_UTF16: send_utf16_token();
          default:   send_utf32_token();
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    mismatches    = 0;
    bytes_sent    = 0;
    hold_req_id   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    // Decoder state after reset: UTF-8, little-endian, nothing pending.
    enc_reg = ENC_UTF8;
    be_reg  = 1'b0;
    clear_sequence_state();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ascii();
    test_utf8();
    test_utf16();
    test_utf32();
    test_backpressure();
    test_random_mix();

    // Let the last characters out, then give stray ones a chance to show.
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_utf_text_decoder: PASS");
    end else begin
      $display("tb_utf_text_decoder: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/utfd_pkg.sv
hdl/utfd_front.sv
hdl/utfd_fifo.sv
hdl/utfd_back.sv
hdl/utf_text_decoder.sv
test/tb_utf_text_decoder.sv
